// File: rtl/core/rgb_pair_to_uyvy_422_macros.svh
// assertion macros shared by the rgb pair to uyvy converter
`ifndef RGB_PAIR_TO_UYVY_422_MACROS_SVH
`define RGB_PAIR_TO_UYVY_422_MACROS_SVH

// antecedent implies consequent in the next cycle
`define RPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define RPU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rpu_pkg.sv
// types and fixed-point constants for the rgb pair to uyvy converter
package rpu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 27;
  localparam int CHAN_W    = ACC_W - FRAC_BITS;

  typedef logic [7:0]                byte_t;
  typedef logic [15:0]               coef_t;
  typedef logic [23:0]               prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [CHAN_W-1:0]  chan_t;

  // bt.601 coefficients, 16 fraction bits
  localparam coef_t K_YR = 16'd16843;
  localparam coef_t K_YG = 16'd33030;
  localparam coef_t K_YB = 16'd6423;
  localparam coef_t K_UR = 16'd9699;
  localparam coef_t K_UG = 16'd19071;
  localparam coef_t K_UB = 16'd28770;
  localparam coef_t K_VR = 16'd28770;
  localparam coef_t K_VG = 16'd24117;
  localparam coef_t K_VB = 16'd4653;

  localparam acc_t OFF_Y = acc_t'(16)  <<< FRAC_BITS;
  localparam acc_t OFF_C = acc_t'(128) <<< FRAC_BITS;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  typedef struct packed {
    chan_t y;
    chan_t u;
    chan_t v;
  } yuv_t;

endpackage

// File: rtl/core/rpu_pixel_conv.sv
// two-stage rgb to yuv conversion of one pixel: products, then sum and floor
module rpu_pixel_conv (
  input  logic             clk,
  input  rpu_pkg::pipe_en_t en,
  input  rpu_pkg::byte_t   red,
  input  rpu_pkg::byte_t   green,
  input  rpu_pkg::byte_t   blue,
  output rpu_pkg::yuv_t    yuv
);
  import rpu_pkg::*;

  prod_t yr_r, yg_r, yb_r;
  prod_t ur_r, ug_r, ub_r;
  prod_t vr_r, vg_r, vb_r;
  yuv_t  yuv_r;
  acc_t  sum_y, sum_u, sum_v;

  // stage 1: nine 8x16 products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      yr_r <= prod_t'(red)   * K_YR;
      yg_r <= prod_t'(green) * K_YG;
      yb_r <= prod_t'(blue)  * K_YB;
      ur_r <= prod_t'(red)   * K_UR;
      ug_r <= prod_t'(green) * K_UG;
      ub_r <= prod_t'(blue)  * K_UB;
      vr_r <= prod_t'(red)   * K_VR;
      vg_r <= prod_t'(green) * K_VG;
      vb_r <= prod_t'(blue)  * K_VB;
    end
  end

  always_comb begin
    sum_y = OFF_Y + acc_t'(yr_r) + acc_t'(yg_r) + acc_t'(yb_r);
    sum_u = OFF_C - acc_t'(ur_r) - acc_t'(ug_r) + acc_t'(ub_r);
    sum_v = OFF_C + acc_t'(vr_r) - acc_t'(vg_r) - acc_t'(vb_r);
  end

  // stage 2: dropping the fraction bits of a two's complement value floors it
  always_ff @(posedge clk) begin
    if (en.s2) begin
      yuv_r.y <= sum_y[ACC_W-1:FRAC_BITS];
      yuv_r.u <= sum_u[ACC_W-1:FRAC_BITS];
      yuv_r.v <= sum_v[ACC_W-1:FRAC_BITS];
    end
  end

  assign yuv = yuv_r;

endmodule

// File: rtl/core/rpu_pack.sv
// chroma averaging, saturation and uyvy output register
module rpu_pack (
  input  logic             clk,
  input  rpu_pkg::pipe_en_t en,
  input  rpu_pkg::yuv_t    yuv_first,
  input  rpu_pkg::yuv_t    yuv_second,
  output rpu_pkg::byte_t   chroma_u,
  output rpu_pkg::byte_t   luma_first,
  output rpu_pkg::byte_t   chroma_v,
  output rpu_pkg::byte_t   luma_second
);
  import rpu_pkg::*;

  typedef logic signed [CHAN_W:0] pair_t;

  byte_t u_r, y0_r, v_r, y1_r;
  pair_t sum_u, sum_v;
  chan_t avg_u, avg_v;

  function automatic byte_t clamp_byte(chan_t x);
    byte_t res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > chan_t'(255)) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  always_comb begin
    sum_u = pair_t'(yuv_first.u) + pair_t'(yuv_second.u);
    sum_v = pair_t'(yuv_first.v) + pair_t'(yuv_second.v);
    // arithmetic halving floors toward minus infinity
    avg_u = sum_u[CHAN_W:1];
    avg_v = sum_v[CHAN_W:1];
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      u_r  <= clamp_byte(avg_u);
      y0_r <= clamp_byte(yuv_first.y);
      v_r  <= clamp_byte(avg_v);
      y1_r <= clamp_byte(yuv_second.y);
    end
  end

  assign chroma_u    = u_r;
  assign luma_first  = y0_r;
  assign chroma_v    = v_r;
  assign luma_second = y1_r;

endmodule

// File: rtl/core/rgb_pair_to_uyvy_422.sv
// Converts a pair of adjacent 8-bit RGB pixels to one BT.601 studio-range
// UYVY 4:2:2 group (U, Y0, V, Y1) with 16-bit fixed-point coefficients,
// floored channels and a floored average of the two chroma samples. It
// accepts one pixel pair per clock unless the output stalls. Its registered
// stages are products, sum with floor, then chroma average and saturation
// into the output register. Each stage moves on when its successor is empty
// or advancing, so a stall at the output holds without losing a transaction.
`include "rgb_pair_to_uyvy_422_macros.svh"

module rgb_pair_to_uyvy_422 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpu_pkg::byte_t in_red_first,
  input  rpu_pkg::byte_t in_green_first,
  input  rpu_pkg::byte_t in_blue_first,
  input  rpu_pkg::byte_t in_red_second,
  input  rpu_pkg::byte_t in_green_second,
  input  rpu_pkg::byte_t in_blue_second,
  output logic           out_valid,
  input  logic           out_ready,
  output rpu_pkg::byte_t out_chroma_u,
  output rpu_pkg::byte_t out_luma_first,
  output rpu_pkg::byte_t out_chroma_v,
  output rpu_pkg::byte_t out_luma_second
);
  import rpu_pkg::*;

  logic     v1_r, v2_r, v3_r;
  logic     v1_nxt, v2_nxt, v3_nxt;
  logic     rdy1, rdy2, rdy3;
  pipe_en_t en;
  yuv_t     yuv_first, yuv_second;

  always_comb begin
    rdy3   = !v3_r || out_ready;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    en.s1  = rdy1 && in_valid;
    en.s2  = rdy2 && v1_r;
    en.s3  = rdy3 && v2_r;
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  rpu_pixel_conv u_conv_first (
    .clk   (clk),
    .en    (en),
    .red   (in_red_first),
    .green (in_green_first),
    .blue  (in_blue_first),
    .yuv   (yuv_first)
  );

  rpu_pixel_conv u_conv_second (
    .clk   (clk),
    .en    (en),
    .red   (in_red_second),
    .green (in_green_second),
    .blue  (in_blue_second),
    .yuv   (yuv_second)
  );

  rpu_pack u_pack (
    .clk         (clk),
    .en          (en),
    .yuv_first   (yuv_first),
    .yuv_second  (yuv_second),
    .chroma_u    (out_chroma_u),
    .luma_first  (out_luma_first),
    .chroma_v    (out_chroma_v),
    .luma_second (out_luma_second)
  );

  assign in_ready  = rdy1;
  assign out_valid = v3_r;

  `RPU_ASSERT_SAME(a_empty_ready, !v1_r && !v2_r && !v3_r, in_ready, "empty pipe not ready")
  `RPU_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v1_r, "accepted transaction lost")
  `RPU_ASSERT_NEXT(a_s1_to_s2, v1_r && rdy2, v2_r, "stage 1 transaction lost")
  `RPU_ASSERT_NEXT(a_drain, out_valid && out_ready && !v2_r, !out_valid, "transaction repeated")

endmodule

// File: dv/rgb_pair_to_uyvy_422_checker.sv
// transaction monitor, uyvy group predictor and scoreboard for the rgb pair converter
`timescale 1ns / 1ps

module rgb_pair_to_uyvy_422_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  rpu_pkg::byte_t in_red_first,
  input  rpu_pkg::byte_t in_green_first,
  input  rpu_pkg::byte_t in_blue_first,
  input  rpu_pkg::byte_t in_red_second,
  input  rpu_pkg::byte_t in_green_second,
  input  rpu_pkg::byte_t in_blue_second,
  input  logic           out_valid,
  input  logic           out_ready,
  input  rpu_pkg::byte_t out_chroma_u,
  input  rpu_pkg::byte_t out_luma_first,
  input  rpu_pkg::byte_t out_chroma_v,
  input  rpu_pkg::byte_t out_luma_second,
  output int             mismatch_count,
  output int             groups_pending
);
  import rpu_pkg::*;

  localparam int SCALE_BITS = 16;
  localparam int LUMA_OFFSET = 16 <<< SCALE_BITS;
  localparam int CHROMA_OFFSET = 128 <<< SCALE_BITS;
  localparam int MAX_REPORTS = 10;

  // bt.601 studio-range matrix, rounded to 16 fraction bits
  localparam int KY_RED = 16843;
  localparam int KY_GREEN = 33030;
  localparam int KY_BLUE = 6423;
  localparam int KU_RED = 9699;
  localparam int KU_GREEN = 19071;
  localparam int KU_BLUE = 28770;
  localparam int KV_RED = 28770;
  localparam int KV_GREEN = 24117;
  localparam int KV_BLUE = 4653;

  typedef struct packed {
    byte_t u;
    byte_t y0;
    byte_t v;
    byte_t y1;
  } uyvy_t;

  uyvy_t uyvy_expected_q[$];

  // arithmetic shift of a signed int floors toward minus infinity
  function automatic int luma_of(input byte_t r, input byte_t g, input byte_t b);
    int acc;
    acc = KY_RED * int'(r) + KY_GREEN * int'(g) + KY_BLUE * int'(b) + LUMA_OFFSET;
    return acc >>> SCALE_BITS;
  endfunction

  function automatic int cb_of(input byte_t r, input byte_t g, input byte_t b);
    int acc;
    acc = -KU_RED * int'(r) - KU_GREEN * int'(g) + KU_BLUE * int'(b) + CHROMA_OFFSET;
    return acc >>> SCALE_BITS;
  endfunction

  function automatic int cr_of(input byte_t r, input byte_t g, input byte_t b);
    int acc;
    acc = KV_RED * int'(r) - KV_GREEN * int'(g) - KV_BLUE * int'(b) + CHROMA_OFFSET;
    return acc >>> SCALE_BITS;
  endfunction

  function automatic byte_t saturate(input int value);
    if (value < 0) begin
      return 8'd0;
    end
    if (value > 255) begin
      return 8'd255;
    end
    return byte_t'(value);
  endfunction

  function automatic uyvy_t predict_uyvy(input byte_t r0, input byte_t g0, input byte_t b0,
                                         input byte_t r1, input byte_t g1, input byte_t b1);
    uyvy_t grp;
    grp.u  = saturate((cb_of(r0, g0, b0) + cb_of(r1, g1, b1)) >>> 1);
    grp.y0 = saturate(luma_of(r0, g0, b0));
    grp.v  = saturate((cr_of(r0, g0, b0) + cr_of(r1, g1, b1)) >>> 1);
    grp.y1 = saturate(luma_of(r1, g1, b1));
    return grp;
  endfunction

  always @(posedge clk) begin
    uyvy_t want;
    uyvy_t got;
    if (!rst_n) begin
      mismatch_count = 0;
      groups_pending = 0;
    end else begin
      if (in_valid && in_ready) begin
        uyvy_expected_q.push_back(predict_uyvy(in_red_first, in_green_first, in_blue_first,
                                               in_red_second, in_green_second,
                                               in_blue_second));
      end
      if (out_valid && out_ready) begin
        got = '{u: out_chroma_u, y0: out_luma_first, v: out_chroma_v, y1: out_luma_second};
        if (uyvy_expected_q.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected uyvy transaction u=%0d y0=%0d v=%0d y1=%0d",
                     $realtime, got.u, got.y0, got.v, got.y1);
          end
        end else begin
          want = uyvy_expected_q.pop_front();
          if (got.u !== want.u || got.y0 !== want.y0 ||
              got.v !== want.v || got.y1 !== want.y1) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: uyvy mismatch expected u=%0d y0=%0d v=%0d y1=%0d",
                       $realtime, want.u, want.y0, want.v, want.y1);
              $display("    got u=%0d y0=%0d v=%0d y1=%0d",
                       got.u, got.y0, got.v, got.y1);
            end
          end
        end
      end
      groups_pending = uyvy_expected_q.size();
    end
  end

endmodule

// File: dv/rgb_pair_to_uyvy_422_tb.sv
// testbench top for the rgb pair to uyvy converter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module rgb_pair_to_uyvy_422_tb;
  import rpu_pkg::*;

  localparam int PHASE_ITEMS = 165;
  localparam int DRAIN_CYCLES = 10;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  byte_t in_red_first;
  byte_t in_green_first;
  byte_t in_blue_first;
  byte_t in_red_second;
  byte_t in_green_second;
  byte_t in_blue_second;
  logic  out_valid;
  logic  out_ready;
  byte_t out_chroma_u;
  byte_t out_luma_first;
  byte_t out_chroma_v;
  byte_t out_luma_second;
  int    mismatch_count;
  int    groups_pending;
  int    send_gap_pct;
  int    recv_gap_pct;

  rgb_pair_to_uyvy_422 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_first   (in_red_first),
    .in_green_first (in_green_first),
    .in_blue_first  (in_blue_first),
    .in_red_second  (in_red_second),
    .in_green_second(in_green_second),
    .in_blue_second (in_blue_second),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chroma_u   (out_chroma_u),
    .out_luma_first (out_luma_first),
    .out_chroma_v   (out_chroma_v),
    .out_luma_second(out_luma_second)
  );

  rgb_pair_to_uyvy_422_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_first   (in_red_first),
    .in_green_first (in_green_first),
    .in_blue_first  (in_blue_first),
    .in_red_second  (in_red_second),
    .in_green_second(in_green_second),
    .in_blue_second (in_blue_second),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_chroma_u   (out_chroma_u),
    .out_luma_first (out_luma_first),
    .out_chroma_v   (out_chroma_v),
    .out_luma_second(out_luma_second),
    .mismatch_count (mismatch_count),
    .groups_pending (groups_pending)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  initial begin
    #4_000_000;
    $display("rgb_pair_to_uyvy_422 verification failed");
    $finish;
  end

  // receiver backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic send_pair(input byte_t r0, input byte_t g0, input byte_t b0,
                           input byte_t r1, input byte_t g1, input byte_t b1);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_red_first    <= r0;
    in_green_first  <= g0;
    in_blue_first   <= b0;
    in_red_second   <= r1;
    in_green_second <= g1;
    in_blue_second  <= b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // hold off the sender until every predicted group has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (groups_pending != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic byte_t pick_component(input int flavor);
    case (flavor)
      0: begin
        return $urandom_range(1) ? 8'd255 : 8'd0;
      end
      1: begin
        return $urandom_range(1) ? byte_t'($urandom_range(255, 248))
                                 : byte_t'($urandom_range(7));
      end
      default: begin
        return byte_t'($urandom_range(255));
      end
    endcase
  endfunction

  task automatic run_phase(input int sender_gap, input int receiver_gap);
    byte_t px[6];
    int    flavor;
    send_gap_pct = sender_gap;
    recv_gap_pct = receiver_gap;
    repeat (PHASE_ITEMS) begin
      flavor = $urandom_range(9);
      for (int i = 0; i < 6; i++) begin
        px[i] = pick_component(flavor < 2 ? flavor : 2);
      end
      // flat areas: both pixels of the pair the same color
      if (flavor == 9) begin
        px[3] = px[0];
        px[4] = px[1];
        px[5] = px[2];
      end
      send_pair(px[0], px[1], px[2], px[3], px[4], px[5]);
    end
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_red_first    = '0;
    in_green_first  = '0;
    in_blue_first   = '0;
    in_red_second   = '0;
    in_green_second = '0;
    in_blue_second  = '0;
    send_gap_pct    = 0;
    recv_gap_pct    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners: black, white, primaries, chroma extremes, bit patterns
    send_gap_pct = 24;
    recv_gap_pct = 69;
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0);
    send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0);
    send_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255);
    send_pair(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0);
    send_pair(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255);
    send_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
    send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    send_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pair(8'd1, 8'd1, 8'd1, 8'd254, 8'd254, 8'd254);
    send_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127);
    send_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    wait_drained();

    run_phase(24, 69);
    run_phase(69, 24);
    run_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rgb_pair_to_uyvy_422 verification clean");
    end else begin
      $display("rgb_pair_to_uyvy_422 verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rpu_pkg.sv
rtl/core/rpu_pixel_conv.sv
rtl/core/rpu_pack.sv
rtl/core/rgb_pair_to_uyvy_422.sv
dv/rgb_pair_to_uyvy_422_checker.sv
dv/rgb_pair_to_uyvy_422_tb.sv
